### rtl/point_in_triangle_classifier_assert.svh
// Assertion macros shared by the point-in-triangle checker.
// No dependencies; include by bare file name.
`ifndef POINT_IN_TRIANGLE_CLASSIFIER_ASSERT_SVH
`define POINT_IN_TRIANGLE_CLASSIFIER_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define PTC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("point_in_triangle_classifier: port check failed");

// Consequent checked from the cycle after the antecedent.
`define PTC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("point_in_triangle_classifier: port check failed");

`endif

### rtl/ptc_pkg.sv
// Shared constants and types for the point-in-triangle classifier.
// No dependencies; imported by every RTL module of the block.
package ptc_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int DATA_WIDTH      = 32;
  localparam int ADDR_WIDTH      = 5;
  localparam int REG_IDX_WIDTH   = 3;

  // Register indexes (byte address = 4 * index)
  localparam logic [REG_IDX_WIDTH-1:0] REG_VA_X = 3'd0;
  localparam logic [REG_IDX_WIDTH-1:0] REG_VA_Y = 3'd1;
  localparam logic [REG_IDX_WIDTH-1:0] REG_VB_X = 3'd2;
  localparam logic [REG_IDX_WIDTH-1:0] REG_VB_Y = 3'd3;
  localparam logic [REG_IDX_WIDTH-1:0] REG_VC_X = 3'd4;
  localparam logic [REG_IDX_WIDTH-1:0] REG_VC_Y = 3'd5;

  // Position codes
  localparam logic [2:0] POS_OUTSIDE = 3'd0;
  localparam logic [2:0] POS_INSIDE  = 3'd1;
  localparam logic [2:0] POS_ON_AB   = 3'd2;
  localparam logic [2:0] POS_ON_BC   = 3'd3;
  localparam logic [2:0] POS_ON_CA   = 3'd4;

  // Sign of one cross product
  typedef struct packed {
    logic zero;
    logic neg;
  } ptc_sign_t;

endpackage

### rtl/ptc_cfg_regs.sv
// Vertex coordinate registers behind the APB-style configuration port.
// Depends on ptc_pkg.
module ptc_cfg_regs #(
  parameter int COORD_WIDTH = ptc_pkg::COORD_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [ptc_pkg::ADDR_WIDTH-1:0]       paddr,
  input  logic [ptc_pkg::DATA_WIDTH-1:0]       pwdata,
  output logic [ptc_pkg::DATA_WIDTH-1:0]       prdata,
  output logic                                 pready,
  output logic signed [COORD_WIDTH-1:0]        vx_o [3],
  output logic signed [COORD_WIDTH-1:0]        vy_o [3]
);
  import ptc_pkg::*;

  logic signed [COORD_WIDTH-1:0] vx_r [3];
  logic signed [COORD_WIDTH-1:0] vy_r [3];
  logic [REG_IDX_WIDTH-1:0]      idx;
  logic                          wr_en;
  logic [COORD_WIDTH-1:0]        wdata;

  assign pready = 1'b1;
  assign idx    = paddr[ADDR_WIDTH-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign wdata  = pwdata[COORD_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        vx_r[i] <= '0;
        vy_r[i] <= '0;
      end
    end else if (wr_en) begin
      case (idx)
        REG_VA_X: vx_r[0] <= wdata;
        REG_VA_Y: vy_r[0] <= wdata;
        REG_VB_X: vx_r[1] <= wdata;
        REG_VB_Y: vy_r[1] <= wdata;
        REG_VC_X: vx_r[2] <= wdata;
        REG_VC_Y: vy_r[2] <= wdata;
        default: ;  // drop writes past the last register
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_VA_X: prdata = DATA_WIDTH'($unsigned(vx_r[0]));
      REG_VA_Y: prdata = DATA_WIDTH'($unsigned(vy_r[0]));
      REG_VB_X: prdata = DATA_WIDTH'($unsigned(vx_r[1]));
      REG_VB_Y: prdata = DATA_WIDTH'($unsigned(vy_r[1]));
      REG_VC_X: prdata = DATA_WIDTH'($unsigned(vx_r[2]));
      REG_VC_Y: prdata = DATA_WIDTH'($unsigned(vy_r[2]));
      default:  prdata = '0;
    endcase
  end

  assign vx_o = vx_r;
  assign vy_o = vy_r;

endmodule

### rtl/ptc_cross_unit.sv
// Three-rank pipelined sign of the cross product (p1 - p0) x (q - p0).
// Depends on ptc_pkg.
module ptc_cross_unit #(
  parameter int COORD_WIDTH = ptc_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic signed [COORD_WIDTH-1:0] x0,
  input  logic signed [COORD_WIDTH-1:0] y0,
  input  logic signed [COORD_WIDTH-1:0] x1,
  input  logic signed [COORD_WIDTH-1:0] y1,
  input  logic signed [COORD_WIDTH-1:0] qx,
  input  logic signed [COORD_WIDTH-1:0] qy,
  output ptc_pkg::ptc_sign_t            sign_o
);
  import ptc_pkg::*;

  localparam int DW = COORD_WIDTH + 1;  // coordinate difference
  localparam int PW = 2 * DW;           // product
  localparam int CW = PW + 1;           // difference of products

  logic signed [DW-1:0] dx_r, dy_r, dqx_r, dqy_r;
  logic signed [PW-1:0] p1_r, p2_r;
  logic signed [CW-1:0] cross_diff;
  ptc_sign_t            sign_r;

  // rank 1: differences
  always_ff @(posedge clk) begin
    dx_r  <= DW'(x1) - DW'(x0);
    dy_r  <= DW'(y1) - DW'(y0);
    dqx_r <= DW'(qx) - DW'(x0);
    dqy_r <= DW'(qy) - DW'(y0);
  end

  // rank 2: products, full width so nothing overflows
  always_ff @(posedge clk) begin
    p1_r <= dx_r * dqy_r;
    p2_r <= dy_r * dqx_r;
  end

  // rank 3: subtract and keep only the sign
  assign cross_diff = CW'(p1_r) - CW'(p2_r);

  always_ff @(posedge clk) begin
    sign_r.zero <= (cross_diff == '0);
    sign_r.neg  <= cross_diff[CW-1];
  end

  assign sign_o = sign_r;

endmodule

### rtl/point_in_triangle_classifier.sv
// Top level of the point-in-triangle classifier: config registers, four cross
// product pipelines and the classification rank. Depends on ptc_pkg,
// ptc_cfg_regs and ptc_cross_unit.
//
//   channel | ports                                    | handshake
//   --------+------------------------------------------+--------------------------
//   input   | in_point_x, in_point_y                   | start && !busy
//   result  | out_position, out_degenerate             | out_valid, one cycle
//   config  | psel penable pwrite paddr pwdata prdata  | APB write, pready high
//
// One point is taken every cycle; each result passes through the four register
// ranks: differences, products, product subtraction and classification. busy is
// always low.
// Reset (rst_n low, synchronous) clears the vertex registers and the valid bits.
// The receiver cannot stall, so words move one rank per cycle and are never held.
module point_in_triangle_classifier #(
  parameter int COORD_WIDTH = ptc_pkg::COORD_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic signed [COORD_WIDTH-1:0]    in_point_x,
  input  logic signed [COORD_WIDTH-1:0]    in_point_y,
  output logic                             out_valid,
  output logic [2:0]                       out_position,
  output logic                             out_degenerate,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ptc_pkg::ADDR_WIDTH-1:0]   paddr,
  input  logic [ptc_pkg::DATA_WIDTH-1:0]   pwdata,
  output logic [ptc_pkg::DATA_WIDTH-1:0]   prdata,
  output logic                             pready
);
  import ptc_pkg::*;

  logic signed [COORD_WIDTH-1:0] vx [3];
  logic signed [COORD_WIDTH-1:0] vy [3];
  logic                          accept;
  logic [3:0]                    vld_r;
  logic [2:0]                    box_nxt, box1_r, box2_r, box3_r;
  ptc_sign_t                     edge_sign [3];
  ptc_sign_t                     deg_sign;
  logic [2:0]                    on_edge;
  logic                          all_pos, all_neg;
  logic [2:0]                    pos_nxt, pos_r;
  logic                          deg_r;

  function automatic logic in_range(input logic signed [COORD_WIDTH-1:0] v,
                                    input logic signed [COORD_WIDTH-1:0] e0,
                                    input logic signed [COORD_WIDTH-1:0] e1);
    return ((v >= e0) && (v <= e1)) || ((v >= e1) && (v <= e0));
  endfunction

  assign busy   = 1'b0;
  assign accept = start && !busy;

  ptc_cfg_regs #(.COORD_WIDTH(COORD_WIDTH)) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .vx_o    (vx),
    .vy_o    (vy)
  );

  // edges AB, BC, CA
  for (genvar e = 0; e < 3; e++) begin : g_edge
    localparam int E1 = (e + 1) % 3;

    ptc_cross_unit #(.COORD_WIDTH(COORD_WIDTH)) u_cross (
      .clk    (clk),
      .x0     (vx[e]),
      .y0     (vy[e]),
      .x1     (vx[E1]),
      .y1     (vy[E1]),
      .qx     (in_point_x),
      .qy     (in_point_y),
      .sign_o (edge_sign[e])
    );

    assign box_nxt[e] = in_range(in_point_x, vx[e], vx[E1]) &&
                        in_range(in_point_y, vy[e], vy[E1]);
  end

  // twice the area: (B - A) x (C - A)
  ptc_cross_unit #(.COORD_WIDTH(COORD_WIDTH)) u_area (
    .clk    (clk),
    .x0     (vx[0]),
    .y0     (vy[0]),
    .x1     (vx[1]),
    .y1     (vy[1]),
    .qx     (vx[2]),
    .qy     (vy[2]),
    .sign_o (deg_sign)
  );

  // bounding-box flags ride alongside the cross pipelines
  always_ff @(posedge clk) begin
    box1_r <= box_nxt;
    box2_r <= box1_r;
    box3_r <= box2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[2:0], accept};
    end
  end

  always_comb begin
    for (int e = 0; e < 3; e++) begin
      on_edge[e] = edge_sign[e].zero && box3_r[e];
    end
    all_pos = !edge_sign[0].zero && !edge_sign[0].neg &&
              !edge_sign[1].zero && !edge_sign[1].neg &&
              !edge_sign[2].zero && !edge_sign[2].neg;
    all_neg = edge_sign[0].neg && edge_sign[1].neg && edge_sign[2].neg;

    // edges first, in order AB, BC, CA
    if (on_edge[0]) begin
      pos_nxt = POS_ON_AB;
    end else if (on_edge[1]) begin
      pos_nxt = POS_ON_BC;
    end else if (on_edge[2]) begin
      pos_nxt = POS_ON_CA;
    end else if (all_pos || all_neg) begin
      pos_nxt = POS_INSIDE;
    end else begin
      pos_nxt = POS_OUTSIDE;
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    deg_r <= deg_sign.zero;
  end

  assign out_valid      = vld_r[3];
  assign out_position   = pos_r;
  assign out_degenerate = deg_r;

endmodule

### rtl/ptc_port_checker.sv
// Port-level checks of the point-in-triangle classifier, bound to the top level.
// Depends on ptc_pkg and point_in_triangle_classifier_assert.svh.
`include "point_in_triangle_classifier_assert.svh"

module ptc_port_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic [2:0] out_position,
  input logic       pready
);
  import ptc_pkg::*;

  // every accepted word comes out on out_valid, and every out_valid traces back to an accepted word
  `PTC_ASSERT_NEXT(a_lat_fwd, clk, rst_n, start && !busy, ##3 out_valid)
  `PTC_ASSERT_SAME(a_lat_bwd, clk, rst_n, out_valid, $past(start && !busy, 4))
  `PTC_ASSERT_SAME(a_pos_code, clk, rst_n, out_valid, out_position <= POS_ON_CA)
  `PTC_ASSERT_SAME(a_always_ready, clk, rst_n, 1'b1, !busy && pready)

endmodule

bind point_in_triangle_classifier ptc_port_checker u_ptc_port_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .out_valid    (out_valid),
  .out_position (out_position),
  .pready       (pready)
);
